>>> src/lbf_pkg.sv
`timescale 1ns / 1ps

package lbf_pkg;

  // Command codes carried in the input item's tuser
  typedef enum logic [2:0] {
    ACT_TICK     = 3'd0,
    ACT_ON       = 3'd1,
    ACT_OFF      = 3'd2,
    ACT_TOGGLE   = 3'd3,
    ACT_SET_LVL  = 3'd4,
    ACT_BREATHE  = 3'd5,
    ACT_FLASH    = 3'd6,
    ACT_QUERY    = 3'd7
  } action_t;

  localparam logic [1:0] MODE_PLAIN  = 2'd0;
  localparam logic [1:0] MODE_BREATH = 2'd1;
  localparam logic [1:0] MODE_FLASH  = 2'd2;

  localparam logic [2:0] CODE_OFF        = 3'd0;
  localparam logic [2:0] CODE_ON         = 3'd1;
  localparam logic [2:0] CODE_BREATH_OFF = 3'd2;
  localparam logic [2:0] CODE_BREATH_ON  = 3'd3;
  localparam logic [2:0] CODE_FLASH_OFF  = 3'd4;
  localparam logic [2:0] CODE_FLASH_ON   = 3'd5;

  localparam logic REG_BREATH_STEPS = 1'b0;
  localparam logic REG_ACTIVE_HIGH  = 1'b1;

  localparam logic [5:0]  STEPS_RESET = 6'd20;
  localparam logic [5:0]  STEPS_MIN   = 6'd2;
  localparam logic [15:0] FLASH_MIN   = 16'd2;
  localparam logic [15:0] FLASH_MAX   = 16'd30000;
  localparam logic [7:0]  LEVEL_FULL  = 8'hFF;

  // Per-LED record held in RAM (lit lives in flops for the pin word)
  typedef struct packed {
    logic [1:0]  mode;
    logic [13:0] tick;
    logic [13:0] duty;     // PWM duty, or flash half period
    logic [13:0] target;   // duty target, or toggles left
  } led_entry_t;

  typedef struct packed {
    logic        is_tick;
    action_t     action;
    logic [7:0]  level;
    logic [15:0] period;
    logic [7:0]  count;
  } lbf_cmd_t;

  typedef struct packed {
    led_entry_t  entry;
    logic        lit;
    logic [2:0]  code;
  } led_upd_t;

  function automatic logic [2:0] led_status(input logic [1:0] mode,
                                            input logic [13:0] target,
                                            input logic lit,
                                            input logic [5:0] steps);
    logic [2:0] code;
    if (mode == MODE_BREATH)
      code = (target < {8'd0, steps}) ? CODE_BREATH_ON : CODE_BREATH_OFF;
    else if (mode == MODE_FLASH)
      code = lit ? CODE_FLASH_ON : CODE_FLASH_OFF;
    else
      code = lit ? CODE_ON : CODE_OFF;
    return code;
  endfunction

endpackage

>>> src/lbf_ram.sv
`timescale 1ns / 1ps

module lbf_ram #(
  parameter int WIDTH = 44,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/lbf_update.sv
`timescale 1ns / 1ps

// Next-state logic for one LED: tick advance or command.
module lbf_update (
  input  lbf_pkg::led_entry_t cur,
  input  logic                cur_lit,
  input  lbf_pkg::lbf_cmd_t   cmd,
  input  logic [5:0]          steps,
  output lbf_pkg::led_upd_t   upd
);
  import lbf_pkg::*;

  led_entry_t  nxt;
  logic        nlit;
  logic [2:0]  st_cur;
  logic [7:0]  lvl;
  logic [13:0] prod;
  logic [14:0] p1;
  logic [14:0] psum;
  logic [5:0]  quot;
  logic [15:0] per;
  logic [13:0] t1;

  assign st_cur = led_status(cur.mode, cur.target, cur_lit, steps);
  assign lvl    = (cmd.action == ACT_SET_LVL) ? cmd.level :
                  (st_cur[0] ? LEVEL_FULL : 8'd0);
  // level*steps/255 via reciprocal: (x+1 + ((x+1)>>8)) >> 8
  assign prod = {6'd0, lvl} * {8'd0, steps};
  assign p1   = {1'b0, prod} + 15'd1;
  assign psum = p1 + (p1 >> 8);
  assign quot = psum[13:8];
  assign per  = (cmd.period < FLASH_MIN) ? FLASH_MIN :
                (cmd.period > FLASH_MAX) ? FLASH_MAX : cmd.period;
  assign t1   = cur.tick + 14'd1;

  always_comb begin
    nxt  = cur;
    nlit = cur_lit;
    if (cmd.is_tick) begin
      case (cur.mode)
        MODE_BREATH: begin
          nxt.tick = t1;
          if (t1 >= {8'd0, steps}) begin
            nlit     = 1'b0;
            nxt.tick = '0;
            if (cur.duty < cur.target)
              nxt.duty = cur.duty + 14'd1;
            else if (cur.duty > cur.target)
              nxt.duty = cur.duty - 14'd1;
          end
          if (nxt.tick == nxt.duty)
            nlit = 1'b1;
        end
        MODE_FLASH: begin
          nxt.tick = t1;
          if (t1 >= cur.duty) begin
            nxt.tick = '0;
            nlit     = ~cur_lit;
            if (cur.target != '0) begin
              nxt.target = cur.target - 14'd1;
              if (cur.target == 14'd1) begin
                nxt  = '0;
                nlit = 1'b0;
              end
            end
          end
        end
        default: ;
      endcase
    end else begin
      case (cmd.action)
        ACT_ON: begin
          nxt  = '0;
          nlit = 1'b1;
        end
        ACT_OFF: begin
          nxt  = '0;
          nlit = 1'b0;
        end
        ACT_TOGGLE: begin
          nxt  = '0;
          nlit = ~cur_lit;
        end
        ACT_SET_LVL, ACT_BREATHE: begin
          if (st_cur == CODE_ON || st_cur == CODE_FLASH_ON)
            nxt.duty = '0;
          else if (st_cur == CODE_OFF || st_cur == CODE_FLASH_OFF)
            nxt.duty = {8'd0, steps};
          nxt.tick   = '0;
          nxt.target = {8'd0, quot};
          nxt.mode   = MODE_BREATH;
        end
        ACT_FLASH: begin
          nxt.mode   = MODE_FLASH;
          nxt.tick   = '0;
          nxt.duty   = per[14:1];
          nxt.target = {5'd0, cmd.count, 1'b0};
          nlit       = 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign upd.entry = nxt;
  assign upd.lit   = nlit;
  assign upd.code  = led_status(nxt.mode, nxt.target, nlit, steps);

endmodule

>>> src/led_breathe_flash_controller_core.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tuser: action; s_tdata: index, level, period, count
// m_*       out  m_tvalid/m_tready  m_tdata: pin_levels, led_state_code
// cfg_*     in   cfg_we             cfg_index selects breath_steps / active_high
//
// A command item passes through accept (RAM read issued), execute and write
// back, and load of the output register. A tick item walks the bank: the
// single RAM read port walks one LED per cycle, write-back trails each read.
// Reset (rst, synchronous) marks every LED record unwritten (reads as zero)
// and darkens all LEDs; no clearing pass. A stalled output register holds the
// finished item and blocks the next one only in its final load step.

module led_breathe_flash_controller_core #(
  parameter int NUM_LEDS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [3:0] led_index, [11:4] brightness,
                                 // [27:12] flash_period_ms, [35:28] flash_count
  input  logic [2:0]  s_tuser,   // [2:0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] pin_levels, [10:8] led_state_code
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data
);
  import lbf_pkg::*;

  localparam int AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int CW = $clog2(NUM_LEDS + 1);
  localparam int EW = $bits(led_entry_t);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_TICK = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state, state_next;

  // config
  logic [5:0] breath_steps;
  logic       active_high;
  logic [5:0] steps;

  // latched command
  lbf_cmd_t       cmd;
  logic [AW-1:0]  cmd_addr;
  logic           cmd_valid;

  // per-LED flops
  logic [NUM_LEDS-1:0] lit;
  logic [NUM_LEDS-1:0] written;

  // tick walk
  logic [CW-1:0] cnt;
  logic          pend;
  logic [AW-1:0] pend_addr;

  // RAM port
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_rdata;
  logic          rd_ok;

  logic [2:0]    code;
  logic [AW-1:0] upd_addr;
  led_entry_t    cur;
  lbf_cmd_t      upd_cmd;
  led_upd_t      upd;
  logic [7:0]    pins;
  logic          s_fire;
  logic          walk_rd;
  logic [4:0]    idx_in;

  assign steps    = (breath_steps < STEPS_MIN) ? STEPS_MIN : breath_steps;
  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign idx_in   = {1'b0, s_tdata[3:0]};
  assign walk_rd  = (state == ST_TICK) && (cnt < CW'(NUM_LEDS));

  always_ff @(posedge clk) begin
    if (rst) begin
      breath_steps <= STEPS_RESET;
      active_high  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BREATH_STEPS: breath_steps <= cfg_data;
        REG_ACTIVE_HIGH:  active_high  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // RAM access control
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = s_tdata[AW-1:0];
    if (s_fire && action_t'(s_tuser) != ACT_TICK) begin
      ram_re = 1'b1;
    end else if (walk_rd) begin
      ram_re    = 1'b1;
      ram_raddr = cnt[AW-1:0];
    end
  end

  assign upd_addr  = (state == ST_TICK) ? pend_addr : cmd_addr;
  assign ram_waddr = upd_addr;
  assign ram_we    = ((state == ST_TICK) && pend) ||
                     ((state == ST_EXEC) && cmd_valid && cmd.action != ACT_QUERY);

  lbf_ram #(.WIDTH(EW), .DEPTH(NUM_LEDS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (upd.entry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // unwritten records read as the reset record
  assign cur = rd_ok ? led_entry_t'(ram_rdata) : '0;

  // tick flag follows the walk state
  always_comb begin
    upd_cmd         = cmd;
    upd_cmd.is_tick = (state == ST_TICK);
  end

  lbf_update u_update (
    .cur     (cur),
    .cur_lit (lit[upd_addr]),
    .cmd     (upd_cmd),
    .steps   (steps),
    .upd     (upd)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_fire)
          state_next = (action_t'(s_tuser) == ACT_TICK) ? ST_TICK : ST_EXEC;
      end
      ST_EXEC: state_next = ST_DONE;
      ST_TICK: begin
        if (!walk_rd && pend)
          state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready)
          state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      lit     <= '0;
      written <= '0;
      pend    <= 1'b0;
      cnt     <= '0;
    end else begin
      state <= state_next;
      if (s_fire) begin
        cnt  <= '0;
        pend <= 1'b0;
      end else if (state == ST_TICK) begin
        pend <= walk_rd;
        if (walk_rd)
          cnt <= cnt + CW'(1);
      end
      if (ram_we) begin
        lit[upd_addr]     <= upd.lit;
        written[upd_addr] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ram_re)
      rd_ok <= written[ram_raddr];
    if (walk_rd)
      pend_addr <= cnt[AW-1:0];
    if (s_fire) begin
      cmd.is_tick <= 1'b0;
      cmd.action  <= action_t'(s_tuser);
      cmd.level   <= s_tdata[11:4];
      cmd.period  <= s_tdata[27:12];
      cmd.count   <= s_tdata[35:28];
      cmd_addr    <= s_tdata[AW-1:0];
      cmd_valid   <= idx_in < 5'(NUM_LEDS);
      code        <= CODE_OFF;
    end else if (state == ST_EXEC) begin
      code <= cmd_valid ? upd.code : CODE_OFF;
    end else if (state == ST_TICK && pend && cmd_valid && pend_addr == cmd_addr) begin
      code <= upd.code;
    end
  end

  // pin word: only the first eight LEDs have a bit
  for (genvar i = 0; i < 8; i++) begin : g_pin
    if (i < NUM_LEDS) begin : g_used
      assign pins[i] = lit[i] ^ ~active_high;
    end else begin : g_none
      assign pins[i] = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!m_tvalid || m_tready))
      m_tdata <= {5'd0, code, pins};
  end

  // the write-back never lands on the entry being read in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("RAM read and write hit the same LED");

  // writes only from the execute step or the tick walk
  a_we_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_EXEC || state == ST_TICK))
    else $error("RAM write outside execute or tick walk");

  // walk counter never runs past the bank size
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(NUM_LEDS))
    else $error("tick walk counter past bank size");

  // an accepted item always starts work in the next cycle
  a_start: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> (state == ST_EXEC || state == ST_TICK))
    else $error("accepted item did not start");

  // reported status is always a defined code
  a_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[10:8] <= CODE_FLASH_ON)
    else $error("status code out of range");

endmodule

>>> test/led_breathe_flash_controller_core_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the LED breathe/flash controller core.
// Commands go in on the s_* stream, one result per command comes out on m_*.
// The bench keeps its own per-LED state and predicts every result.
module led_breathe_flash_controller_core_tb;
  import lbf_pkg::*;

  localparam int NUM_LEDS = 8;
  localparam int ITEMS_PER_PHASE = 100;   // five register settings, ~500 items total
  localparam int N_PHASES = 5;

  // One command item as the bench sees it
  typedef struct {
    action_t     act;
    logic [3:0]  idx;
    logic [7:0]  level;
    logic [15:0] period;
    logic [7:0]  count;
    bit          drain;   // sender holds this item until all results are back
  } led_cmd_t;

  // One result item
  typedef struct {
    logic [7:0] pins;
    logic [2:0] code;
  } led_view_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // [3:0] led_index, [11:4] brightness,
                               // [27:12] flash_period_ms, [35:28] flash_count
  logic [2:0]  s_tuser = '0;   // [2:0] action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [7:0] pin_levels, [10:8] led_state_code
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [5:0]  cfg_data = '0;

  led_breathe_flash_controller_core #(
    .NUM_LEDS(NUM_LEDS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the LED bank: per-LED mode, counter, duty (or half period),
  // target (or toggles left) and lit flag, plus the two registers.
  // ---------------------------------------------------------------------------
  logic [1:0]  led_mode [NUM_LEDS];
  logic [13:0] led_tick [NUM_LEDS];
  logic [13:0] led_duty [NUM_LEDS];
  logic [13:0] led_goal [NUM_LEDS];
  logic        led_lit  [NUM_LEDS];
  logic [5:0]  steps_reg = STEPS_RESET;
  logic        polarity_reg = 1'b1;

  // breath_steps below the floor behaves as the floor
  function automatic logic [13:0] eff_steps();
    if (steps_reg < STEPS_MIN)
      return {8'd0, STEPS_MIN};
    return {8'd0, steps_reg};
  endfunction

  function automatic logic [2:0] led_code(int i);
    case (led_mode[i])
      MODE_BREATH: return (led_goal[i] < eff_steps()) ? CODE_BREATH_ON : CODE_BREATH_OFF;
      MODE_FLASH:  return led_lit[i] ? CODE_FLASH_ON : CODE_FLASH_OFF;
      default:     return led_lit[i] ? CODE_ON : CODE_OFF;
    endcase
  endfunction

  function automatic void make_plain(int i, logic on);
    led_mode[i] = MODE_PLAIN;
    led_tick[i] = '0;
    led_duty[i] = '0;
    led_goal[i] = '0;
    led_lit[i]  = on;
  endfunction

  // Enter breathing toward level*S/255. Duty starts from the visible state
  // unless the LED already breathes, in which case it is kept.
  function automatic void start_fade(int i, logic [7:0] level);
    logic [13:0] s;
    logic [2:0]  code;
    int unsigned goal;
    s = eff_steps();
    code = led_code(i);
    if (code == CODE_ON || code == CODE_FLASH_ON)
      led_duty[i] = '0;
    else if (code == CODE_OFF || code == CODE_FLASH_OFF)
      led_duty[i] = s;
    led_tick[i] = '0;
    goal = 32'(level);
    goal = goal * s / LEVEL_FULL;
    led_goal[i] = goal[13:0];
    led_mode[i] = MODE_BREATH;
  endfunction

  // One 1 ms tick across the whole bank
  function automatic void advance_all();
    logic [13:0] s;
    s = eff_steps();
    for (int i = 0; i < NUM_LEDS; i++) begin
      if (led_mode[i] == MODE_BREATH) begin
        led_tick[i] = led_tick[i] + 14'd1;
        if (led_tick[i] >= s) begin
          // PWM period wraps: pin goes dark, duty walks one step to target
          led_lit[i]  = 1'b0;
          led_tick[i] = '0;
          if (led_duty[i] < led_goal[i])
            led_duty[i] = led_duty[i] + 14'd1;
          else if (led_duty[i] > led_goal[i])
            led_duty[i] = led_duty[i] - 14'd1;
        end
        if (led_tick[i] == led_duty[i])
          led_lit[i] = 1'b1;
      end else if (led_mode[i] == MODE_FLASH) begin
        led_tick[i] = led_tick[i] + 14'd1;
        if (led_tick[i] >= led_duty[i]) begin
          led_tick[i] = '0;
          led_lit[i]  = ~led_lit[i];
          // zero toggles left means flash forever
          if (led_goal[i] != '0) begin
            led_goal[i] = led_goal[i] - 14'd1;
            if (led_goal[i] == '0)
              make_plain(i, 1'b0);
          end
        end
      end
    end
  endfunction

  // Apply one command to the shadow and return the result it should produce
  function automatic led_view_t run_cmd(led_cmd_t c);
    led_view_t   v;
    int          i;
    logic [15:0] per;
    logic [2:0]  code;
    i = int'(c.idx);
    if (c.act == ACT_TICK) begin
      advance_all();
    end else if (i < NUM_LEDS) begin
      case (c.act)
        ACT_ON:      make_plain(i, 1'b1);
        ACT_OFF:     make_plain(i, 1'b0);
        ACT_TOGGLE:  make_plain(i, ~led_lit[i]);
        ACT_SET_LVL: start_fade(i, c.level);
        ACT_BREATHE: begin
          // lit now -> fade to dark, otherwise fade to full
          code = led_code(i);
          start_fade(i, code[0] ? LEVEL_FULL : 8'h00);
        end
        ACT_FLASH: begin
          per = c.period;
          if (per < FLASH_MIN) per = FLASH_MIN;
          if (per > FLASH_MAX) per = FLASH_MAX;
          led_mode[i] = MODE_FLASH;
          led_tick[i] = '0;
          led_duty[i] = per[14:1];
          led_goal[i] = {5'd0, c.count, 1'b0};
          led_lit[i]  = 1'b1;
        end
        default: ;
      endcase
    end
    v.pins = '0;
    for (int k = 0; k < NUM_LEDS && k < 8; k++)
      v.pins[k] = polarity_reg ? led_lit[k] : ~led_lit[k];
    v.code = (i < NUM_LEDS) ? led_code(i) : CODE_OFF;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Queues and counters
  // ---------------------------------------------------------------------------
  led_cmd_t  cmd_q[$];       // commands waiting to be sent
  led_view_t result_q[$];    // predicted results, oldest first
  led_cmd_t  tx_cmd;
  bit        tx_busy = 1'b0; // an item is on the bus and not yet taken
  int        tx_gap = 0;
  int        stall_left = 0;
  bit        calm = 1'b0;    // no idling on either side
  int        sent_cnt = 0;
  int        tick_cnt = 0;
  int        checked_cnt = 0;
  int        err_cnt = 0;

  task automatic flag_error(string what, int want, int got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("ERROR @%0t: %s expected 'h%0h got 'h%0h", $time, what, want, got);
  endtask

  function automatic void push_cmd(action_t a, int idx, int level, int period,
                                   int count, bit drain);
    led_cmd_t c;
    c.act    = a;
    c.idx    = 4'(idx);
    c.level  = 8'(level);
    c.period = 16'(period);
    c.count  = 8'(count);
    c.drain  = drain;
    cmd_q.push_back(c);
  endfunction

  // Random fields, biased to short flash periods and few flashes so that
  // flashes finish and breathing gets many ticks; the full range still shows up.
  function automatic led_cmd_t random_cmd(action_t a);
    led_cmd_t c;
    int       r;
    c.act = a;
    if ($urandom_range(0, 9) != 0)
      c.idx = 4'($urandom_range(0, NUM_LEDS - 1));
    else
      c.idx = 4'($urandom_range(8, 15));
    r = $urandom_range(0, 9);
    if (r < 2)
      c.level = r ? 8'hFF : 8'h00;
    else
      c.level = 8'($urandom);
    r = $urandom_range(0, 19);
    if (r < 12)
      c.period = 16'($urandom_range(0, 24));
    else if (r < 15)
      c.period = 16'($urandom_range(25, 400));
    else if (r == 15)
      c.period = 16'($urandom_range(29990, 30010));
    else if (r == 16)
      c.period = 16'($urandom_range(0, 3));
    else
      c.period = 16'($urandom);
    if ($urandom_range(0, 9) < 6)
      c.count = 8'($urandom_range(0, 3));
    else
      c.count = 8'($urandom);
    c.drain = ($urandom_range(0, 49) == 0);
    return c;
  endfunction

  // Queue a random command, or now and then a run of ticks; returns items added
  function automatic int push_random();
    int r;
    int run;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      run = $urandom_range(5, 70);
      for (int k = 0; k < run; k++)
        cmd_q.push_back(random_cmd(ACT_TICK));
      return run;
    end
    if (r < 45)
      cmd_q.push_back(random_cmd(ACT_TICK));
    else
      cmd_q.push_back(random_cmd(action_t'($urandom_range(1, 7))));
    return 1;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued items, predicts each one when it is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_busy = 1'b0;
      tx_gap = 0;
    end else if (s_tvalid && !s_tready) begin
      // item still waiting; hold everything
    end else begin
      if (s_tvalid) begin
        // item taken at this edge
        result_q.push_back(run_cmd(tx_cmd));
        tx_busy = 1'b0;
        sent_cnt++;
        if (tx_cmd.act == ACT_TICK)
          tick_cnt++;
      end
      if (tx_gap > 0) begin
        tx_gap--;
        s_tvalid <= 1'b0;
      end else if (cmd_q.size() != 0 && (!cmd_q[0].drain || result_q.size() == 0)) begin
        tx_cmd = cmd_q.pop_front();
        tx_busy = 1'b1;
        s_tuser  <= tx_cmd.act;
        s_tdata  <= {4'd0, tx_cmd.count, tx_cmd.period, tx_cmd.level, tx_cmd.idx};
        s_tvalid <= 1'b1;
        tx_gap = calm ? 0 : $urandom_range(0, 12);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: takes results with random back-pressure, checks field by field
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : rx_side
    led_view_t want;
    int        nstall;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else if (m_tvalid && m_tready) begin
      if (result_q.size() == 0) begin
        flag_error("result with nothing outstanding, m_tdata", 0, int'(m_tdata));
      end else begin
        want = result_q.pop_front();
        if (m_tdata[7:0] !== want.pins)
          flag_error("pin_levels", int'(want.pins), int'(m_tdata[7:0]));
        if (m_tdata[10:8] !== want.code)
          flag_error("led_state_code", int'(want.code), int'(m_tdata[10:8]));
      end
      checked_cnt++;
      nstall = calm ? 0 : $urandom_range(0, 12);
      stall_left = nstall;
      m_tready <= (nstall == 0);
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= (stall_left == 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and register control
  // ---------------------------------------------------------------------------

  // Wait until nothing is queued, on the bus or outstanding, then let a tick
  // walk finish with margin.
  task automatic settle();
    while (cmd_q.size() != 0 || tx_busy || result_q.size() != 0)
      @(posedge clk);
    repeat (NUM_LEDS + 6) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [5:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BREATH_STEPS)
      steps_reg = value;
    else
      polarity_reg = value[0];
  endtask

  initial begin : stimulus
    logic [5:0] steps_set [N_PHASES];
    logic       pol_set   [N_PHASES];
    int         n;

    // settings per phase; both extremes of breath_steps plus the sub-floor values
    steps_set[0] = 6'd0;  pol_set[0] = 1'b0;
    steps_set[1] = 6'd63; pol_set[1] = 1'b1;
    steps_set[2] = 6'd1;  pol_set[2] = 1'b1;
    steps_set[3] = 6'd2;  pol_set[3] = 1'b0;
    steps_set[4] = 6'd37; pol_set[4] = 1'b1;

    for (int i = 0; i < NUM_LEDS; i++)
      make_plain(i, 1'b0);
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset register values (S = 20, active high)
    push_cmd(ACT_QUERY,   0,   0,     0,   0, 0);  // reset state
    push_cmd(ACT_QUERY,   15, 255, 65535, 255, 0);  // out of range, all-ones fields
    push_cmd(ACT_ON,      0,   0,     0,   0, 0);
    push_cmd(ACT_TOGGLE,  1,   0,     0,   0, 0);
    push_cmd(ACT_TOGGLE,  1,   0,     0,   0, 0);
    push_cmd(ACT_ON,      9,   0,     0,   0, 0);  // ignored
    push_cmd(ACT_SET_LVL, 2,   0,     0,   0, 0);  // from dark plain, brightest target
    push_cmd(ACT_SET_LVL, 3, 255,     0,   0, 0);  // fade to dark
    push_cmd(ACT_BREATHE, 4,   0,     0,   0, 0);  // dark plain -> full
    push_cmd(ACT_BREATHE, 0,   0,     0,   0, 0);  // lit plain -> dark
    push_cmd(ACT_FLASH,   5,   0,     0,   0, 0);  // period clamps up, forever
    push_cmd(ACT_FLASH,   6,   0, 65535, 255, 0);  // period clamps down
    push_cmd(ACT_FLASH,   7,   0,     1,   1, 0);  // one flash, half period 1
    push_cmd(ACT_FLASH,   12,  0,     4,   1, 0);  // ignored
    push_cmd(ACT_SET_LVL, 8,  77,     0,   0, 0);  // ignored
    push_cmd(ACT_TICK,    0,   0,     0,   0, 1);  // sender waits for a full drain
    repeat (4) push_cmd(ACT_TICK, 0, 0, 0, 0, 0);
    push_cmd(ACT_BREATHE, 5,   0,     0,   0, 0);  // from flashing
    push_cmd(ACT_SET_LVL, 2, 128,     0,   0, 0);  // already breathing: duty kept
    push_cmd(ACT_QUERY,   7,   0,     0,   0, 0);
    push_cmd(ACT_TOGGLE,  6,   0,     0,   0, 0);  // flashing -> plain
    push_cmd(ACT_OFF,     15,  0,     0,   0, 0);  // ignored
    settle();

    // Random part, one register setting per phase; one phase runs without idling
    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_reg(REG_BREATH_STEPS, steps_set[ph]);
      write_reg(REG_ACTIVE_HIGH, {5'd0, pol_set[ph]});
      calm = (ph == 2);
      n = 0;
      while (n < ITEMS_PER_PHASE)
        n += push_random();
      settle();
    end

    $display("Covered %0d commands (%0d ticks) under %0d register settings,",
             sent_cnt, tick_cnt, N_PHASES + 1);
    $display("%0d results checked, %0d mismatches.", checked_cnt, err_cnt);
    if (err_cnt == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Timeout: %0d results still outstanding", result_q.size());
    $display("tb: failure");
    $finish;
  end

endmodule

>>> led_breathe_flash_controller_core.f
src/lbf_pkg.sv
src/lbf_ram.sv
src/lbf_update.sv
src/led_breathe_flash_controller_core.sv
test/led_breathe_flash_controller_core_tb.sv
